// File: hdl/fixed_point_calculator_alu_top_defines.svh
// Assertion macros for the fixed-point calculator ALU checker.
// Used by the checker file only; no dependencies.
`ifndef FIXED_POINT_CALCULATOR_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_CALCULATOR_ALU_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpc check failed");

// Next-cycle implication, disabled during reset.
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpc check failed");

`endif

// File: hdl/fpc_pkg.sv
// Shared types, codes and helper functions of the fixed-point calculator ALU.
// No dependencies.
package fpc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned NumW      = 48;
  localparam int unsigned CordicN   = 23;
  localparam int unsigned DivN      = 48;
  localparam logic [31:0] MaxPos    = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg    = 32'h8000_0000;
  localparam logic [47:0] C32       = 48'h20_0000;
  localparam logic [23:0] AngHalf   = 24'h5A_0000;
  localparam logic [23:0] AngFull   = 24'hB4_0000;
  localparam logic [16:0] Recip180  = 17'd93207;

  typedef enum logic [3:0] {
    OP_MUL   = 4'd0,
    OP_DIV   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_AVG   = 4'd4,
    OP_ABS   = 4'd5,
    OP_F2C   = 4'd6,
    OP_C2F   = 4'd7,
    OP_TAN   = 4'd8,
    OP_ROUND = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_SAT   = 2'd2,
    ST_BADOP = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] res;
    status_e     st;
  } res_t;

  typedef struct packed {
    op_e                op;
    logic               done;
    logic               neg;
    res_t               r;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
    logic [47:0]        num;
    logic [31:0]        den;
    logic [31:0]        rem;
    logic [47:0]        quo;
  } item_t;

  function automatic res_t sat(input logic neg, input logic [47:0] mag);
    res_t o;
    o.st = ST_OK;
    if (!neg) begin
      if (mag > 48'h7FFF_FFFF) begin
        o.res = MaxPos;
        o.st  = ST_SAT;
      end else begin
        o.res = mag[31:0];
      end
    end else begin
      if (mag > 48'h8000_0000) begin
        o.res = MinNeg;
        o.st  = ST_SAT;
      end else begin
        o.res = 32'd0 - mag[31:0];
      end
    end
    return o;
  endfunction

  // Arctangent of 2^-i in degrees, 16 fraction bits.
  function automatic logic signed [25:0] atan_deg(input int unsigned i);
    logic signed [25:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/fpc_if.sv
// Request and response channel interfaces of the fixed-point calculator ALU.
// No dependencies.
interface fpc_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;
  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

// File: hdl/fixed_point_calculator_alu_top.sv
// Fixed-point calculator ALU, Q16.16: decode stage, 23 CORDIC cells, 48 divider cells.
// Stages from accepted transaction to result: decode, prepare,
// 23 CORDIC cells, setup, 48 restoring-division cells and the output register.
// Throughput is one transaction per cycle while the output is not stalled; every cell holds its own item and valid bit.
// Reset clears all valid bits; data registers are not reset.
// Depends on fpc_pkg, fpc_if, fpc_cordic_cell, fpc_div_cell.
module fixed_point_calculator_alu_top
  import fpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  fpc_in_if.sink   in_i,
  fpc_out_if.source out_o
);

  // Stage A: decode, simple operations, products
  logic        a_v_q, a_rdy;
  item_t       a_q, a_d;
  logic [63:0] a_prod_q, a_prod_d;
  logic [32:0] a_t_q, a_t_d;

  logic [31:0] au, bu, am, bm;
  logic        an, bn;
  logic signed [32:0] s_add, s_sub, s_avg;
  logic [32:0] fmag;
  logic        fneg;
  logic [16:0] rnd_ip;

  assign au = unsigned'(in_i.operand_a);
  assign bu = unsigned'(in_i.operand_b);
  assign an = au[31];
  assign bn = bu[31];
  assign am = an ? (~au + 32'd1) : au;
  assign bm = bn ? (~bu + 32'd1) : bu;
  assign s_add = {in_i.operand_a[31], in_i.operand_a} + {in_i.operand_b[31], in_i.operand_b};
  assign s_sub = {in_i.operand_a[31], in_i.operand_a} - {in_i.operand_b[31], in_i.operand_b};
  assign rnd_ip = {1'b0, am[31:16]} + 17'(am[15:0] > 16'h8000);

  always_comb begin
    fneg = 1'b0;
    fmag = 33'({1'b0, am}) + 33'(C32);
    if (!an) begin
      if (48'(am) >= C32) begin
        fmag = 33'(am) - 33'(C32);
      end else begin
        fmag = 33'(C32) - 33'(am);
        fneg = 1'b1;
      end
    end else begin
      fneg = 1'b1;
    end
  end

  always_comb begin
    a_d    = '0;
    a_d.op = op_e'(in_i.opcode);
    s_avg  = s_add >>> 1;
    if (s_add[0] && s_avg[32]) begin
      s_avg = s_avg + 33'sd1;
    end
    a_prod_d = 64'(am) * 64'(bm);
    a_t_d    = 33'(am[31:16]) * 33'(Recip180);
    case (op_e'(in_i.opcode))
      OP_MUL: a_d.neg = an ^ bn;
      OP_DIV: begin
        if (bm == 32'd0) begin
          a_d.done = 1'b1;
          a_d.r    = '{res: 32'd0, st: ST_DIV0};
        end
        a_d.neg = an ^ bn;
        a_d.num = {am, 16'h0000};
        a_d.den = bm;
      end
      OP_ADD: begin
        a_d.done = 1'b1;
        if (s_add[32] != s_add[31]) begin
          a_d.r = '{res: (s_add[32] ? MinNeg : MaxPos), st: ST_SAT};
        end else begin
          a_d.r = '{res: s_add[31:0], st: ST_OK};
        end
      end
      OP_SUB: begin
        a_d.done = 1'b1;
        if (s_sub[32] != s_sub[31]) begin
          a_d.r = '{res: (s_sub[32] ? MinNeg : MaxPos), st: ST_SAT};
        end else begin
          a_d.r = '{res: s_sub[31:0], st: ST_OK};
        end
      end
      OP_AVG: begin
        a_d.done = 1'b1;
        a_d.r    = '{res: s_avg[31:0], st: ST_OK};
      end
      OP_ABS: begin
        a_d.done = 1'b1;
        a_d.r    = sat(1'b0, 48'(am));
      end
      OP_F2C: begin
        a_d.neg = fneg;
        a_d.num = 48'({fmag, 2'b00}) + 48'(fmag);
        a_d.den = 32'd9;
      end
      OP_C2F: begin
        a_d.neg = an;
        a_d.num = 48'({am, 3'b000}) + 48'(am);
        a_d.den = 32'd5;
      end
      OP_TAN: begin
        a_d.neg = an;
        a_d.num = 48'(am);
      end
      OP_ROUND: begin
        a_d.done = 1'b1;
        a_d.r    = sat(an, 48'({rnd_ip, 16'h0000}));
      end
      default: begin
        a_d.done = 1'b1;
        a_d.r    = '{res: 32'd0, st: ST_BADOP};
      end
    endcase
  end

  // Stage B: finish multiply, reduce the tangent angle, seed CORDIC
  logic        b_v_q, b_rdy;
  item_t       b_q, b_d;
  logic [8:0]  tq;
  logic [16:0] tq180;
  logic [15:0] r16;
  logic [23:0] ang;

  assign tq    = a_t_q[32:24];
  assign tq180 = 17'(tq) * 17'd180;
  assign r16   = a_q.num[31:16] - tq180[15:0];

  always_comb begin
    b_d = a_q;
    ang = {r16[7:0], a_q.num[15:0]};
    case (a_q.op)
      OP_MUL: begin
        b_d.done = 1'b1;
        if (a_prod_q[63:48] != 16'h0000) begin
          b_d.r = sat(a_q.neg, '1);
        end else begin
          b_d.r = sat(a_q.neg, a_prod_q[63:16]);
        end
      end
      OP_TAN: begin
        if (ang > AngHalf) begin
          ang     = AngFull - ang;
          b_d.neg = !a_q.neg;
        end
        b_d.x = 34'sd1073741824;
        b_d.y = 34'sd0;
        b_d.z = 26'(signed'({2'b00, ang}));
        if (ang == AngHalf) begin
          b_d.done = 1'b1;
          b_d.r    = '{res: MaxPos, st: ST_SAT};
        end
      end
      default: ;
    endcase
  end

  // CORDIC chain
  logic  c_v   [CordicN+1];
  logic  c_rdy [CordicN+1];
  item_t c_item[CordicN+1];

  assign c_v[0]    = b_v_q;
  assign c_item[0] = b_q;

  for (genvar i = 0; i < CordicN; i++) begin : g_cordic
    fpc_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(c_v[i]),
      .ready_o(c_rdy[i]),
      .item_i (c_item[i]),
      .valid_o(c_v[i+1]),
      .ready_i(c_rdy[i+1]),
      .item_o (c_item[i+1])
    );
  end

  // Stage S: set up the tangent division, clear the remainder
  logic  s_v_q, s_rdy;
  item_t s_q, s_d;
  item_t cl;
  logic  yneg;
  logic [33:0] yabs;

  assign cl   = c_item[CordicN];
  assign yneg = cl.y[33];
  assign yabs = yneg ? 34'(-cl.y) : 34'(cl.y);

  always_comb begin
    s_d     = cl;
    s_d.rem = '0;
    s_d.quo = '0;
    if (cl.op == OP_TAN && !cl.done) begin
      s_d.neg = cl.neg ^ yneg;
      if (cl.x[33] || cl.x == 34'sd0) begin
        s_d.done = 1'b1;
        s_d.r    = sat(cl.neg ^ yneg, '1);
      end else begin
        s_d.num = {yabs[31:0], 16'h0000};
        s_d.den = cl.x[31:0];
      end
    end
  end

  // Division chain
  logic  d_v   [DivN+1];
  logic  d_rdy [DivN+1];
  item_t d_item[DivN+1];

  assign d_v[0]    = s_v_q;
  assign d_item[0] = s_q;

  for (genvar i = 0; i < DivN; i++) begin : g_div
    fpc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(d_v[i]),
      .ready_o(d_rdy[i]),
      .item_i (d_item[i]),
      .valid_o(d_v[i+1]),
      .ready_i(d_rdy[i+1]),
      .item_o (d_item[i+1])
    );
  end

  // Output register
  logic  o_v_q, o_rdy;
  res_t  o_q, o_d;
  item_t dl;

  assign dl = d_item[DivN];

  always_comb begin
    o_d = dl.r;
    if (!dl.done) begin
      case (dl.op)
        OP_C2F: begin
          if (!dl.neg) begin
            o_d = sat(1'b0, dl.quo + C32);
          end else if (dl.quo >= C32) begin
            o_d = sat(1'b1, dl.quo - C32);
          end else begin
            o_d = sat(1'b0, C32 - dl.quo);
          end
        end
        default: o_d = sat(dl.neg, dl.quo);
      endcase
    end
  end

  // Handshake chain: a stage advances when empty or when its successor moves
  assign o_rdy           = !o_v_q || out_o.ready;
  assign d_rdy[DivN]     = o_rdy;
  assign s_rdy           = !s_v_q || d_rdy[0];
  assign c_rdy[CordicN]  = s_rdy;
  assign b_rdy           = !b_v_q || c_rdy[0];
  assign a_rdy           = !a_v_q || b_rdy;
  assign in_i.ready      = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_i.valid;
      if (b_rdy) b_v_q <= a_v_q;
      if (s_rdy) s_v_q <= c_v[CordicN];
      if (o_rdy) o_v_q <= d_v[DivN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_i.valid) begin
      a_q      <= a_d;
      a_prod_q <= a_prod_d;
      a_t_q    <= a_t_d;
    end
    if (b_rdy && a_v_q) b_q <= b_d;
    if (s_rdy && c_v[CordicN]) s_q <= s_d;
    if (o_rdy && d_v[DivN]) o_q <= o_d;
  end

  assign out_o.valid  = o_v_q;
  assign out_o.result = signed'(o_q.res);
  assign out_o.status = o_q.st;

endmodule

// File: hdl/fpc_cordic_cell.sv
// One CORDIC rotation cell of the tangent chain, with its own pipeline register.
// Depends on fpc_pkg.
module fpc_cordic_cell
  import fpc_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  localparam logic signed [25:0] Atan = atan_deg(STEP);

  logic  v_q;
  item_t item_q, item_d;
  logic signed [33:0] xs, ys;

  assign ready_o = !v_q || ready_i;
  assign xs = item_i.x >>> STEP;
  assign ys = item_i.y >>> STEP;

  always_comb begin
    item_d = item_i;
    if (!item_i.z[25]) begin
      item_d.x = item_i.x - ys;
      item_d.y = item_i.y + xs;
      item_d.z = item_i.z - Atan;
    end else begin
      item_d.x = item_i.x + ys;
      item_d.y = item_i.y - xs;
      item_d.z = item_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = item_q;

endmodule

// File: hdl/fpc_div_cell.sv
// One restoring-division cell: produces one quotient bit per item per cycle while its successor is ready.
// Depends on fpc_pkg.
module fpc_div_cell
  import fpc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  v_q;
  item_t item_q, item_d;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  assign ready_o = !v_q || ready_i;
  assign rem_sh  = {item_i.rem, item_i.num[47]};
  assign rem_sub = rem_sh - {1'b0, item_i.den};
  assign ge      = rem_sh >= {1'b0, item_i.den};

  always_comb begin
    item_d     = item_i;
    item_d.rem = ge ? rem_sub[31:0] : rem_sh[31:0];
    item_d.num = {item_i.num[46:0], 1'b0};
    item_d.quo = {item_i.quo[46:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = item_q;

endmodule

// File: hdl/fpc_checker.sv
// Port-level checker for the fixed-point calculator ALU, bound to the top level.
// Depends on fpc_pkg and fixed_point_calculator_alu_top_defines.svh.
`include "fixed_point_calculator_alu_top_defines.svh"

module fpc_checker
  import fpc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_result_i,
  input logic [1:0]  out_status_i
);

  // Hold a stalled transaction.
  `FPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_result_i) && $stable(out_status_i))
  `FPC_ASSERT_IMPL(a_div0_zero, clk_i, rst_ni, out_valid_i && out_status_i == ST_DIV0, out_result_i == 32'd0)
  `FPC_ASSERT_IMPL(a_badop_zero, clk_i, rst_ni, out_valid_i && out_status_i == ST_BADOP, out_result_i == 32'd0)
  `FPC_ASSERT_IMPL(a_sat_limit, clk_i, rst_ni, out_valid_i && out_status_i == ST_SAT, out_result_i == MaxPos || out_result_i == MinNeg)

endmodule

bind fixed_point_calculator_alu_top fpc_checker u_fpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_result_i(out_o.result),
  .out_status_i(out_o.status)
);

// File: bench/tb_fixed_point_calculator_alu_top.sv
// Testbench for the fixed-point calculator ALU: random and directed operations
// over valid/ready channels, checked against a Q16.16 predictor in a scoreboard.
// Depends on fpc_pkg, fpc_if and fixed_point_calculator_alu_top.
`timescale 1ns / 100ps

class alu_scoreboard;
  fpc_pkg::res_t want_q[$];
  int unsigned   mismatches;

  localparam longint AtanDeg[23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  function new();
    mismatches = 0;
  endfunction

  // Clamp a magnitude with a sign into the 32-bit signed range.
  function fpc_pkg::res_t clamp(bit neg, logic [63:0] mag);
    fpc_pkg::res_t o;
    o.st = fpc_pkg::ST_OK;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        o.res = 32'h7FFF_FFFF;
        o.st  = fpc_pkg::ST_SAT;
      end else begin
        o.res = mag[31:0];
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        o.res = 32'h8000_0000;
        o.st  = fpc_pkg::ST_SAT;
      end else begin
        o.res = 32'd0 - mag[31:0];
      end
    end
    return o;
  endfunction

  function fpc_pkg::res_t tangent(bit neg, logic [63:0] mag);
    longint unsigned p, h, r;
    longint x, y, z, xs, ys;
    bit yneg;
    fpc_pkg::res_t o;
    p = 64'd180 << 16;
    h = 64'd90 << 16;
    r = mag % p;
    x = 64'sd1 << 30;
    y = 0;
    if (r > h) begin
      r = p - r;
      neg = !neg;
    end
    if (r == h) begin
      o.res = 32'h7FFF_FFFF;
      o.st  = fpc_pkg::ST_SAT;
      return o;
    end
    z = longint'(r);
    for (int i = 0; i < 23; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanDeg[i];
      end else begin
        x += ys; y -= xs; z += AtanDeg[i];
      end
    end
    yneg = y < 0;
    if (x <= 0) return clamp(neg != yneg, '1);
    return clamp(neg != yneg, ((yneg ? -y : y) << 16) / x);
  endfunction

  function fpc_pkg::res_t compute(logic [3:0] op, logic signed [31:0] ai,
                                  logic signed [31:0] bi);
    longint a, b, s, v;
    longint unsigned am, bm, q, c32;
    bit an, bn;
    fpc_pkg::res_t o;
    a = ai; b = bi;
    an = a < 0; bn = b < 0;
    am = an ? -a : a;
    bm = bn ? -b : b;
    c32 = 64'd32 << 16;
    o.st = fpc_pkg::ST_OK;
    o.res = '0;
    case (op)
      fpc_pkg::OP_MUL: o = clamp(an != bn, (am * bm) >> 16);
      fpc_pkg::OP_DIV: begin
        if (bm == 0) o.st = fpc_pkg::ST_DIV0;
        else o = clamp(an != bn, (am << 16) / bm);
      end
      fpc_pkg::OP_ADD, fpc_pkg::OP_SUB: begin
        s = (op == fpc_pkg::OP_ADD) ? a + b : a - b;
        o = clamp(s < 0, s < 0 ? -s : s);
      end
      fpc_pkg::OP_AVG: begin
        s = (a + b) / 2;
        o.res = s[31:0];
      end
      fpc_pkg::OP_ABS: o = clamp(1'b0, am);
      fpc_pkg::OP_F2C: begin
        v = a - longint'(c32);
        o = clamp(v < 0, ((v < 0 ? -v : v) * 5) / 9);
      end
      fpc_pkg::OP_C2F: begin
        q = (am * 9) / 5;
        if (!an) o = clamp(1'b0, q + c32);
        else if (q >= c32) o = clamp(1'b1, q - c32);
        else o = clamp(1'b0, c32 - q);
      end
      fpc_pkg::OP_TAN: o = tangent(an, am);
      fpc_pkg::OP_ROUND: begin
        q = am >> 16;
        if ((am & 64'hFFFF) > 64'h8000) q += 1;
        o = clamp(an, q << 16);
      end
      default: o.st = fpc_pkg::ST_BADOP;
    endcase
    return o;
  endfunction

  function void note_request(logic [3:0] op, logic signed [31:0] a,
                             logic signed [31:0] b);
    want_q.push_back(compute(op, a, b));
  endfunction

  function void check_response(logic [31:0] res, logic [1:0] st);
    fpc_pkg::res_t w;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response res=%h st=%0d", res, st);
      return;
    end
    w = want_q.pop_front();
    if (w.res !== res || w.st !== st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected res=%h st=%0d, got res=%h st=%0d",
                 w.res, w.st, res, st);
    end
  endfunction
endclass

module tb_fixed_point_calculator_alu_top;
  import fpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam logic [3:0]  OpBadFirst = OP_ROUND + 4'd1;
  localparam logic [3:0]  OpBadLast  = 4'hF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  bit hold_rx = 1'b0;

  fpc_in_if  req_bus ();
  fpc_out_if rsp_bus ();

  alu_scoreboard sb = new();

  fixed_point_calculator_alu_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_bus),
    .out_o (rsp_bus)
  );

  always #5 clk = ~clk;

  initial begin
    req_bus.valid = 1'b0;
    req_bus.opcode = '0;
    req_bus.operand_a = '0;
    req_bus.operand_b = '0;
    rsp_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one transaction after a random gap and hold it until accepted.
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    int unsigned gap;
    gap = $urandom_range(13);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.opcode    <= op;
    req_bus.operand_a <= a;
    req_bus.operand_b <= b;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(op, a, b);
    accepted++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return 32'($signed($urandom_range(400)) - 200) << 16 | 32'($urandom_range(65535));
      3: return (32'($signed($urandom_range(8)) - 4) * 32'd90) << 16;
      4: return {$urandom_range(1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
      default: return 32'($signed($urandom_range(20)) - 10) << 16 | 32'h8000;
    endcase
  endfunction

  // Response side: random stalls, plus one long hold from its own process.
  always @(posedge clk) begin : rx_side
    static int unsigned wait_cnt = 0;
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_response(rsp_bus.result, rsp_bus.status);
        wait_cnt = ($urandom_range(3) == 0) ? 0 : $urandom_range(13);
      end else if (wait_cnt != 0) begin
        wait_cnt--;
      end
      rsp_bus.ready <= (wait_cnt == 0) && !hold_rx;
    end
  end

  initial begin
    wait (accepted >= 300);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    logic [3:0] op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed corners: extremes, divide by zero, ties, tangent poles, bad codes.
    send_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_MUL, 32'h8000_0000, 32'h0001_0000);
    send_op(OP_MUL, 32'h8000_0000, 32'hFFFF_0000);
    send_op(OP_DIV, 32'h0003_0000, 32'h0000_0000);
    send_op(OP_DIV, 32'h8000_0000, 32'h0000_0001);
    send_op(OP_DIV, 32'hFFF9_0000, 32'h0002_0000);
    send_op(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    send_op(OP_ADD, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_op(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_AVG, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_op(OP_AVG, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_ABS, 32'h8000_0000, 32'h0);
    send_op(OP_ABS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_F2C, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_F2C, 32'h8000_0000, 32'h0);
    send_op(OP_C2F, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_C2F, 32'h8000_0000, 32'h0);
    send_op(OP_TAN, 32'h005A_0000, 32'h0);
    send_op(OP_TAN, 32'hFFA6_0000, 32'h0);
    send_op(OP_TAN, 32'h002D_0000, 32'h0);
    send_op(OP_ROUND, 32'h0002_8000, 32'h0);
    send_op(OP_ROUND, 32'hFFFD_8000, 32'h0);
    send_op(OP_ROUND, 32'h7FFF_FFFF, 32'h0);
    send_op(OpBadFirst, 32'h1234_5678, 32'h0);
    send_op(OpBadLast, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int n = 0; n < 1300; n++) begin
      if ($urandom_range(15) == 0) op = OpBadFirst + 4'($urandom_range(5));
      else op = 4'($urandom_range(OP_ROUND));
      send_op(op, pick_operand(), ($urandom_range(19) == 0) ? 32'h0 : pick_operand());
    end
    // Drop valid at the edge that took the last transaction.
    req_bus.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
